@@ rtl/hrp_pkg.sv @@
// Package for the HTTP request header parser.
// Holds byte codes, role codes, the GET text and the word types; no dependencies.
package hrp_pkg;

  localparam int MAX_LINES_DEFAULT = 128;
  localparam int LINE_W = 7;

  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_COLON = 8'h3A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  typedef enum logic [2:0] {
    ROLE_METHOD  = 3'd0,
    ROLE_URL     = 3'd1,
    ROLE_VERSION = 3'd2,
    ROLE_NAME    = 3'd3,
    ROLE_VALUE   = 3'd4,
    ROLE_SEP     = 3'd5,
    ROLE_IGNORED = 3'd6
  } role_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } in_word_t;

  typedef struct packed {
    role_t             role;
    logic [LINE_W-1:0] line_number;
    logic              line_end;
    logic              headers_done;
    logic              method_is_get;
    logic              line_overflow;
  } result_t;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/http_request_header_parser_core.sv @@
// Top level of the HTTP request header parser.
// Instantiates hrp_in_stage, hrp_parse and hrp_out_stage; uses hrp_pkg.
//
// The core tags each byte of an HTTP request with its role, line number and
// line-end status, one result word for every input word, in order. It takes
// one byte per cycle while the consumer does not stall. Each byte is held in
// the input register and its result word in the result register. The rate
// is set by the parse stage, which updates the whole parser state for each
// byte it takes. An input register and a result register part the two sides,
// so one further byte is taken while a result waits on a stalled consumer.
// Setting new_request with a byte clears all parser state before that byte.
module http_request_header_parser_core
  import hrp_pkg::*;
#(
  parameter int MAX_LINES = MAX_LINES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              new_request,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        role,
  output logic [LINE_W-1:0] line_number,
  output logic              line_end,
  output logic              headers_done,
  output logic              method_is_get,
  output logic              line_overflow
);

  in_word_t in_word;
  in_word_t held_word;
  logic     held_valid;
  logic     advance;
  logic     fire;
  result_t  res;
  result_t  out_word;

  assign in_word.data_byte   = data_byte;
  assign in_word.new_request = new_request;
  assign fire = held_valid && advance;

  hrp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  hrp_parse #(
    .MAX_LINES (MAX_LINES)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .word (held_word),
    .res  (res)
  );

  hrp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign role          = out_word.role;
  assign line_number   = out_word.line_number;
  assign line_end      = out_word.line_end;
  assign headers_done  = out_word.headers_done;
  assign method_is_get = out_word.method_is_get;
  assign line_overflow = out_word.line_overflow;

endmodule

@@ rtl/hrp_in_stage.sv @@
// Input register of the header parser.
// Holds one accepted word until the parse stage takes it; uses hrp_pkg.
module hrp_in_stage
  import hrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     advance,
  output logic     held_valid,
  output in_word_t held_word
);

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_word <= in_word;
    end
  end

endmodule

@@ rtl/hrp_parse.sv @@
// Parse stage: parser state registers and the per-byte next-state logic.
// Produces one result word per consumed byte; uses hrp_pkg.
module hrp_parse
  import hrp_pkg::*;
#(
  parameter int MAX_LINES = MAX_LINES_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_word_t word,
  output result_t  res
);

  localparam int LAST_INT = (MAX_LINES - 1 > 127) ? 127 : MAX_LINES - 1;
  localparam logic [LINE_W-1:0] LAST_LINE = LAST_INT[LINE_W-1:0];

  logic              last_was_cr, last_was_cr_next;
  logic [LINE_W-1:0] current_line, current_line_next;
  logic              line_length, line_length_next;
  logic              colon_seen, colon_seen_next;
  logic [1:0]        space_count, space_count_next;
  logic [1:0]        get_match_progress, get_match_progress_next;
  logic              get_mismatch, get_mismatch_next;
  logic              finished, finished_next;
  logic              overflowed, overflowed_next;

  always_comb begin
    logic [7:0] b;
    b = word.data_byte;
    if (word.new_request) begin
      last_was_cr_next        = 1'b0;
      current_line_next       = '0;
      line_length_next        = 1'b0;
      colon_seen_next         = 1'b0;
      space_count_next        = 2'd0;
      get_match_progress_next = 2'd0;
      get_mismatch_next       = 1'b0;
      finished_next           = 1'b0;
      overflowed_next         = 1'b0;
    end else begin
      last_was_cr_next        = last_was_cr;
      current_line_next       = current_line;
      line_length_next        = line_length;
      colon_seen_next         = colon_seen;
      space_count_next        = space_count;
      get_match_progress_next = get_match_progress;
      get_mismatch_next       = get_mismatch;
      finished_next           = finished;
      overflowed_next         = overflowed;
    end

    res.line_number  = current_line_next;
    res.line_end     = 1'b0;
    res.headers_done = 1'b0;
    res.role         = ROLE_IGNORED;

    if (finished_next) begin
      res.role = ROLE_IGNORED;
    end else if (b == BYTE_LF && last_was_cr_next) begin
      res.role     = ROLE_SEP;
      res.line_end = 1'b1;
      if (!line_length_next) begin
        res.headers_done = 1'b1;
        finished_next    = 1'b1;
      end else if (current_line_next >= LAST_LINE) begin
        current_line_next = LAST_LINE;
        overflowed_next   = 1'b1;
      end else begin
        current_line_next = current_line_next + 1'b1;
      end
      last_was_cr_next = 1'b0;
      line_length_next = 1'b0;
      colon_seen_next  = 1'b0;
    end else begin
      if (b != BYTE_CR || last_was_cr_next) begin
        line_length_next = 1'b1;
      end
      if (current_line_next == '0) begin
        if (b == BYTE_SPACE && space_count_next < 2'd2) begin
          res.role         = ROLE_SEP;
          space_count_next = space_count_next + 1'b1;
        end else if (space_count_next == 2'd0) begin
          res.role = ROLE_METHOD;
          if (!get_mismatch_next) begin
            if (get_match_progress_next < 2'd3 &&
                b == get_char(get_match_progress_next)) begin
              get_match_progress_next = get_match_progress_next + 1'b1;
            end else begin
              get_mismatch_next = 1'b1;
            end
          end
        end else if (space_count_next == 2'd1) begin
          res.role = ROLE_URL;
        end else begin
          res.role = ROLE_VERSION;
        end
      end else if (!colon_seen_next && b == BYTE_COLON) begin
        res.role        = ROLE_SEP;
        colon_seen_next = 1'b1;
      end else begin
        res.role = colon_seen_next ? ROLE_VALUE : ROLE_NAME;
      end
      last_was_cr_next = (b == BYTE_CR);
    end

    res.method_is_get = (get_match_progress_next == 2'd3) && !get_mismatch_next;
    res.line_overflow = overflowed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_was_cr        <= 1'b0;
      current_line       <= '0;
      line_length        <= 1'b0;
      colon_seen         <= 1'b0;
      space_count        <= 2'd0;
      get_match_progress <= 2'd0;
      get_mismatch       <= 1'b0;
      finished           <= 1'b0;
      overflowed         <= 1'b0;
    end else if (fire) begin
      last_was_cr        <= last_was_cr_next;
      current_line       <= current_line_next;
      line_length        <= line_length_next;
      colon_seen         <= colon_seen_next;
      space_count        <= space_count_next;
      get_match_progress <= get_match_progress_next;
      get_mismatch       <= get_mismatch_next;
      finished           <= finished_next;
      overflowed         <= overflowed_next;
    end
  end

`ifndef ASSERT_OFF
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    fire && overflowed && !word.new_request |=> overflowed)
    else $error("line overflow flag cleared without a new request");

  a_done_finishes: assert property (@(posedge clk) disable iff (rst)
    fire && res.headers_done |=> finished)
    else $error("end of headers did not stop parsing");

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    current_line <= LAST_LINE)
    else $error("line counter beyond last line");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    fire && res.role == ROLE_IGNORED |-> !res.line_end && !res.headers_done)
    else $error("ignored byte reported a line end");
`endif

endmodule

@@ rtl/hrp_out_stage.sv @@
// Result register of the header parser.
// Holds one result word until the consumer takes it; uses hrp_pkg.
module hrp_out_stage
  import hrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    out_stall,
  output logic    advance,
  output logic    out_valid,
  output result_t out_word
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= res;
    end
  end

endmodule

@@ tb/tb_http_request_header_parser_core.sv @@
// Testbench for http_request_header_parser_core: drives HTTP request bytes and checks each
// result word against a behavioral model of the parser kept in the testbench.
// Depends on hrp_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_http_request_header_parser_core;
  import hrp_pkg::*;

  localparam logic [LINE_W-1:0] TOP_LINE =
      (MAX_LINES_DEFAULT - 1 > 127) ? 7'd127 : LINE_W'(MAX_LINES_DEFAULT - 1);
  localparam logic [23:0] GET_WORD = "GET";

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        data_byte;
  logic              new_request;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        role;
  logic [LINE_W-1:0] line_number;
  logic              line_end;
  logic              headers_done;
  logic              method_is_get;
  logic              line_overflow;

  logic              prs_last_cr;
  logic [LINE_W-1:0] prs_line;
  logic              prs_nonempty;
  logic              prs_colon;
  logic [1:0]        prs_spaces;
  logic [1:0]        prs_get_pos;
  logic              prs_get_bad;
  logic              prs_done;
  logic              prs_ovf;

  result_t pending_tags[$];
  int      errors = 0;
  int      sent_items = 0;
  bit      idle_on = 1'b1;

  http_request_header_parser_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .new_request  (new_request),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .role         (role),
    .line_number  (line_number),
    .line_end     (line_end),
    .headers_done (headers_done),
    .method_is_get(method_is_get),
    .line_overflow(line_overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 28);
  end

  function automatic void clear_parser();
    prs_last_cr  = 1'b0;
    prs_line     = '0;
    prs_nonempty = 1'b0;
    prs_colon    = 1'b0;
    prs_spaces   = 2'd0;
    prs_get_pos  = 2'd0;
    prs_get_bad  = 1'b0;
    prs_done     = 1'b0;
    prs_ovf      = 1'b0;
  endfunction

  function automatic result_t tag_byte(input logic [7:0] b, input logic nr);
    result_t r;
    if (nr) clear_parser();
    r.role         = ROLE_IGNORED;
    r.line_number  = prs_line;
    r.line_end     = 1'b0;
    r.headers_done = 1'b0;
    if (prs_done) begin
      r.role = ROLE_IGNORED;
    end else if (b == BYTE_LF && prs_last_cr) begin
      r.role     = ROLE_SEP;
      r.line_end = 1'b1;
      if (!prs_nonempty) begin
        r.headers_done = 1'b1;
        prs_done       = 1'b1;
      end else if (prs_line >= TOP_LINE) begin
        prs_line = TOP_LINE;
        prs_ovf  = 1'b1;
      end else begin
        prs_line = prs_line + 1'b1;
      end
      prs_last_cr  = 1'b0;
      prs_nonempty = 1'b0;
      prs_colon    = 1'b0;
    end else begin
      if (b != BYTE_CR || prs_last_cr) prs_nonempty = 1'b1;
      if (prs_line == 0) begin
        if (b == BYTE_SPACE && prs_spaces < 2) begin
          r.role     = ROLE_SEP;
          prs_spaces = prs_spaces + 1'b1;
        end else if (prs_spaces == 0) begin
          r.role = ROLE_METHOD;
          if (!prs_get_bad) begin
            if (prs_get_pos < 3 && b == GET_WORD[23 - 8 * prs_get_pos -: 8]) begin
              prs_get_pos = prs_get_pos + 1'b1;
            end else begin
              prs_get_bad = 1'b1;
            end
          end
        end else if (prs_spaces == 1) begin
          r.role = ROLE_URL;
        end else begin
          r.role = ROLE_VERSION;
        end
      end else if (!prs_colon && b == BYTE_COLON) begin
        r.role    = ROLE_SEP;
        prs_colon = 1'b1;
      end else if (prs_colon) begin
        r.role = ROLE_VALUE;
      end else begin
        r.role = ROLE_NAME;
      end
      prs_last_cr = (b == BYTE_CR);
    end
    r.method_is_get = (prs_get_pos == 3) && !prs_get_bad;
    r.line_overflow = prs_ovf;
    return r;
  endfunction

  function automatic logic [7:0] rand_content();
    case ($urandom_range(0, 19))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return BYTE_SPACE;
      3:       return BYTE_COLON;
      4:       return BYTE_CR;
      5:       return BYTE_LF;
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_tag;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tags.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual role %0d line %0d",
                 $time, role, line_number);
        errors++;
      end else begin
        exp_tag = pending_tags.pop_front();
        check_field("role", exp_tag.role, role);
        check_field("line_number", exp_tag.line_number, line_number);
        check_field("line_end", exp_tag.line_end, line_end);
        check_field("headers_done", exp_tag.headers_done, headers_done);
        check_field("method_is_get", exp_tag.method_is_get, method_is_get);
        check_field("line_overflow", exp_tag.line_overflow, line_overflow);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic nr);
    result_t exp_tag;
    while (idle_on && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    new_request <= nr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_tag = tag_byte(b, nr);
    pending_tags.push_back(exp_tag);
    sent_items++;
  endtask

  task automatic send_text(input string s, input logic nr_first);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], (i == 0) ? nr_first : 1'b0);
    end
  endtask

  task automatic send_random_chars(input int n);
    repeat (n) send_byte(rand_content(), 1'b0);
  endtask

  task automatic send_random_request();
    logic start;
    int   n_hdr;
    int   pick;
    start = ($urandom_range(0, 19) != 0);
    pick  = $urandom_range(0, 9);
    if (pick < 5) begin
      send_text("GET", start);
    end else if (pick < 7) begin
      send_byte(rand_content(), start);
      send_random_chars($urandom_range(0, 4));
    end else begin
      case ($urandom_range(0, 2))
        0:       send_text("GE", start);
        1:       send_text("GETS", start);
        default: send_text("get", start);
      endcase
    end
    send_byte(BYTE_SPACE, 1'b0);
    send_random_chars($urandom_range(0, 6));
    send_byte(BYTE_SPACE, 1'b0);
    send_random_chars($urandom_range(0, 6));
    send_text("\015\n", 1'b0);
    n_hdr = $urandom_range(0, 5);
    repeat (n_hdr) begin
      send_random_chars($urandom_range(0, 5));
      if ($urandom_range(0, 9) != 0) send_byte(BYTE_COLON, 1'b0);
      send_random_chars($urandom_range(0, 6));
      send_text("\015\n", 1'b0);
    end
    if ($urandom_range(0, 9) != 0) send_text("\015\n", 1'b0);
    send_random_chars($urandom_range(0, 3));
  endtask

  task automatic test_basic_get();
    send_text("GET / H\015\nA:b:\015\n\015\nz", 1'b1);
  endtask

  task automatic test_special_cases();
    // An empty request line ends the headers at once.
    send_text("\015\nx", 1'b1);
    // CR inside the method, colon in the request line, extra spaces, CR as content.
    send_text("GE\015T a:b c d\015q\015\n", 1'b1);
    // Lone LF, byte extremes and a CR CR LF line end.
    send_byte(8'h0A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text(":\015\015\n\015\n", 1'b0);
  endtask

  task automatic test_line_saturation();
    send_text("GET / H\015\n", 1'b1);
    repeat (130) send_text("n\015\n", 1'b0);
    send_text("v\015\n\015\nq", 1'b0);
  endtask

  task automatic test_random_traffic();
    int n;
    while (sent_items < 1250) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 20);
        repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end else begin
        send_random_request();
      end
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (10) send_random_request();
    idle_on = 1'b1;
  endtask

  initial begin
    int wait_cycles;
    in_valid    = 1'b0;
    data_byte   = 8'h00;
    new_request = 1'b0;
    rst         = 1'b1;
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_basic_get();
    test_special_cases();
    test_line_saturation();
    test_random_traffic();
    test_steady_stream();
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_tags.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (pending_tags.size() != 0) begin
      $display("%0t: expected %0d more result words, actual none", $time, pending_tags.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hrp_pkg.sv
rtl/hrp_in_stage.sv
rtl/hrp_parse.sv
rtl/hrp_out_stage.sv
rtl/http_request_header_parser_core.sv
tb/tb_http_request_header_parser_core.sv
